// ----- rtl/bb3_pkg.sv -----
package bb3_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned WIDTH_W     = 11;
  localparam int unsigned HEIGHT_W    = 12;
  localparam int unsigned ROW_W       = 13;
  localparam int unsigned SUM_W       = 12;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // floor(s / 9) == (s * 7282) >> 16 for every 3x3 sum of 8-bit pixels
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
  } line_pair_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic use_l;
    logic use_r;
    logic use_t;
    logic use_b;
  } tap_ctrl_t;

endpackage

// ----- rtl/bb3_stream_if.sv -----
interface bb3_pix_in_if;
  logic             valid;
  logic             ready;
  bb3_pkg::pixel_t  pixel_value;
  logic             drain;

  modport source (output valid, output pixel_value, output drain, input ready);
  modport sink (input valid, input pixel_value, input drain, output ready);
endinterface

interface bb3_pix_out_if;
  logic             valid;
  logic             ready;
  bb3_pkg::pixel_t  blurred_value;
  logic             last_of_frame;

  modport source (output valid, output blurred_value, output last_of_frame, input ready);
  modport sink (input valid, input blurred_value, input last_of_frame, output ready);
endinterface

// ----- rtl/bb3_line_mem.sv -----
module bb3_line_mem #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        re_i,
  input  logic [$clog2(DEPTH)-1:0]    raddr_i,
  output bb3_pkg::line_pair_t         rdata_o,
  input  logic                        we_i,
  input  logic [$clog2(DEPTH)-1:0]    waddr_i,
  input  bb3_pkg::line_pair_t         wdata_i
);

  localparam int unsigned FW = $clog2(DEPTH + 1);

  bb3_pkg::line_pair_t line_mem_q [DEPTH];
  bb3_pkg::line_pair_t rdata_q;
  logic [FW-1:0]       fill_q, fill_d;

  // columns are first written in order from zero, so entries at or above
  // the fill mark have not been written since reset and read as zero
  always_comb begin
    fill_d = fill_q;
    if (we_i && (FW'(waddr_i) == fill_q)) begin
      fill_d = fill_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      line_mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-first bypass when an item reads the column its predecessor writes
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else if (FW'(raddr_i) >= fill_q) begin
        rdata_q <= '0;
      end else begin
        rdata_q <= line_mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bb3_ctrl.sv -----
module bb3_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [bb3_pkg::WIDTH_W-1:0]       cfg_width_i,
  input  logic [bb3_pkg::HEIGHT_W-1:0]      cfg_height_i,
  input  logic                              accept_i,
  output logic [$clog2(MAX_WIDTH)-1:0]      addr_o,
  output bb3_pkg::tap_ctrl_t                taps_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW = EW + 1;
  localparam int unsigned RW = bb3_pkg::ROW_W;

  logic [EW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [CW-1:0] col_q, col_d, col0, xc;
  logic [RW-1:0] row_q, row_d, row0, yc;
  logic [XW-1:0] col_inc;
  logic          restart;
  logic          emit;
  logic          last;

  always_comb begin
    if (cfg_width_i == '0) begin
      eff_w = EW'(1);
    end else if (32'(cfg_width_i) > 32'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_width_i);
    end
    eff_h = (cfg_height_i == '0) ? RW'(1) : RW'(cfg_height_i);
  end

  always_comb begin
    restart = (XW'(col_q) >= XW'(eff_w)) || (row_q > eff_h + RW'(1));
    col0    = restart ? '0 : col_q;
    row0    = restart ? '0 : row_q;

    // center of the window sits one column behind the arriving item
    if (col0 != '0) begin
      emit = (row0 != '0);
      xc   = col0 - CW'(1);
      yc   = row0 - RW'(1);
    end else begin
      emit = (row0 >= RW'(2));
      xc   = CW'(eff_w - EW'(1));
      yc   = row0 - RW'(2);
    end
    emit = emit && (yc < eff_h);
    last = (XW'(xc) + XW'(1) == XW'(eff_w)) && (yc + RW'(1) == eff_h);

    taps_o.emit  = emit;
    taps_o.last  = last;
    taps_o.use_l = (xc != '0);
    taps_o.use_r = (XW'(xc) + XW'(1) < XW'(eff_w));
    taps_o.use_t = (yc != '0);
    taps_o.use_b = (yc + RW'(1) < eff_h);
    addr_o       = col0;

    col_inc = XW'(col0) + XW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept_i) begin
      if (emit && last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= XW'(eff_w)) begin
        col_d = '0;
        row_d = row0 + RW'(1);
      end else begin
        col_d = CW'(col_inc);
        row_d = row0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- rtl/bb3_window.sv -----
module bb3_window #(
  parameter int unsigned AW = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [AW-1:0]                   addr_i,
  input  bb3_pkg::pixel_t                 pixel_i,
  input  bb3_pkg::tap_ctrl_t              taps_i,
  input  bb3_pkg::line_pair_t             rd_i,
  output logic                            ready_o,
  output logic                            wr_en_o,
  output logic [AW-1:0]                   wr_addr_o,
  output bb3_pkg::line_pair_t             wr_data_o,
  input  logic                            s2_ready_i,
  output logic                            s2_valid_o,
  output logic [bb3_pkg::SUM_W-1:0]       s2_sum_o,
  output logic                            s2_last_o
);

  localparam int unsigned SW = bb3_pkg::SUM_W;

  logic                  s1_v_q, s1_v_d;
  logic [AW-1:0]         s1_addr_q;
  bb3_pkg::pixel_t       s1_pix_q;
  bb3_pkg::tap_ctrl_t    s1_taps_q;
  bb3_pkg::column_t      hist_q [2];
  bb3_pkg::column_t      col_new;
  logic                  s2_v_q, s2_v_d;
  logic [SW-1:0]         s2_sum_q;
  logic                  s2_last_q;
  logic [SW-1:0]         win_sum;
  logic                  s1_adv, s2_adv, s1_move;

  function automatic logic [SW-1:0] col_sum(bb3_pkg::column_t col, logic use_t,
                                            logic use_b);
    logic [SW-1:0] s;
    s = SW'(col.mid);
    if (use_t) s = s + SW'(col.top);
    if (use_b) s = s + SW'(col.bot);
    return s;
  endfunction

  always_comb begin
    s2_adv  = !s2_v_q || s2_ready_i;
    s1_adv  = !s1_v_q || s2_adv;
    s1_move = s1_v_q && s1_adv;
    ready_o = s1_adv;

    col_new.top = rd_i.top;
    col_new.mid = rd_i.mid;
    col_new.bot = s1_pix_q;

    win_sum = col_sum(hist_q[1], s1_taps_q.use_t, s1_taps_q.use_b);
    if (s1_taps_q.use_l) win_sum = win_sum + col_sum(hist_q[0], s1_taps_q.use_t,
                                                     s1_taps_q.use_b);
    if (s1_taps_q.use_r) win_sum = win_sum + col_sum(col_new, s1_taps_q.use_t,
                                                     s1_taps_q.use_b);

    wr_en_o       = s1_move;
    wr_addr_o     = s1_addr_q;
    wr_data_o.top = rd_i.mid;
    wr_data_o.mid = s1_pix_q;

    s1_v_d = s1_adv ? accept_i : s1_v_q;
    s2_v_d = s2_adv ? (s1_v_q && s1_taps_q.emit) : s2_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      hist_q[0] <= '0;
      hist_q[1] <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      if (s1_move) begin
        hist_q[0] <= hist_q[1];
        hist_q[1] <= col_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_addr_q <= addr_i;
      s1_pix_q  <= pixel_i;
      s1_taps_q <= taps_i;
    end
    if (s2_adv) begin
      s2_sum_q  <= win_sum;
      s2_last_q <= s1_taps_q.last;
    end
  end

  assign s2_valid_o = s2_v_q;
  assign s2_sum_o   = s2_sum_q;
  assign s2_last_o  = s2_last_q;

endmodule

// ----- rtl/box_blur_3x3.sv -----
// 3x3 box blur over an 8-bit grayscale frame streamed in raster order.
// in_i carries one pixel per item (pixel_value, drain); out_o carries one
// blurred pixel per item (blurred_value, last_of_frame). Both channels use
// valid/ready and move an item on a clock edge where both are high.
// Frame size comes from the write port: index 0 is the width (1..MAX_WIDTH),
// index 1 the height. Write only while the block is idle.
// Each blurred pixel leaves once the pixel below and to the right has come in,
// so the host follows the frame with width+1 drain items; the last one
// produces the pixel flagged last_of_frame. An emitting item passes through
// the stage 1, stage 2 and output registers before it shows on out_o.
// Throughput is one item per cycle unless out_o stalls: every item reads and
// writes back one column of the two-row line memory, one read and one write
// port per cycle. Reset sets 640x480, clears the position counters, the window,
// all valid flags and the fill mark of the line memory; columns at or above the
// mark have not been written since reset and read as zero, so no clearing pass
// is needed. When out_o stalls the output register and the two stages behind it
// hold their items, and in_i.ready falls once all are full.
module box_blur_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  bb3_pix_in_if.sink                          in_i,
  bb3_pix_out_if.source                       out_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

  logic [bb3_pkg::WIDTH_W-1:0]   width_q, width_d;
  logic [bb3_pkg::HEIGHT_W-1:0]  height_q, height_d;
  logic                          accept;
  bb3_pkg::pixel_t               pixel;
  logic [AW-1:0]                 rd_addr;
  bb3_pkg::tap_ctrl_t            taps;
  bb3_pkg::line_pair_t           rd_data;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  bb3_pkg::line_pair_t           wr_data;
  logic                          s2_valid;
  logic [bb3_pkg::SUM_W-1:0]     s2_sum;
  logic                          s2_last;
  logic                          out_adv;
  logic [PW-1:0]                 prod;
  logic                          out_v_q, out_v_d;
  bb3_pkg::pixel_t               out_val_q;
  logic                          out_last_q;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (bb3_pkg::cfg_reg_e'(cfg_index_i))
        bb3_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i[bb3_pkg::WIDTH_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i[bb3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_i.valid && in_i.ready;
  assign pixel  = in_i.drain ? '0 : in_i.pixel_value;

  bb3_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .accept_i     (accept),
    .addr_o       (rd_addr),
    .taps_o       (taps)
  );

  bb3_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data)
  );

  bb3_window #(
    .AW (AW)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .addr_i     (rd_addr),
    .pixel_i    (pixel),
    .taps_i     (taps),
    .rd_i       (rd_data),
    .ready_o    (in_i.ready),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .s2_ready_i (out_adv),
    .s2_valid_o (s2_valid),
    .s2_sum_o   (s2_sum),
    .s2_last_o  (s2_last)
  );

  // divide by nine through the reciprocal
  always_comb begin
    out_adv = !out_v_q || out_o.ready;
    out_v_d = out_adv ? s2_valid : out_v_q;
    prod    = PW'(s2_sum) * PW'(bb3_pkg::RECIP_NINE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bb3_pkg::WIDTH_RESET;
      height_q <= bb3_pkg::HEIGHT_RESET;
      out_v_q  <= 1'b0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_val_q  <= prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::PIX_W];
      out_last_q <= s2_last;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.blurred_value = out_val_q;
  assign out_o.last_of_frame = out_last_q;

endmodule

// ----- rtl/bb3_checker.sv -----
module bb3_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input bb3_pkg::pixel_t  out_value_i,
  input logic             out_last_i
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_value_i) && $stable(out_last_i))
    else $error("stalled result item changed");

  // input side only stops when the output side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input not ready while output can drain");

  // nothing leaves right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result item valid coming out of reset");

  // out_valid is never unknown after an input item is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$isunknown(out_valid_i))
    else $error("output valid unknown after an accepted item");

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.blurred_value),
  .out_last_i  (out_o.last_of_frame)
);

// ----- tb/sv/tb_box_blur_3x3.sv -----
module tb_box_blur_3x3;

  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned STALL_LIMIT  = 5000;

  typedef struct packed {
    bb3_pkg::pixel_t value;
    logic            frame_end;
  } blur_px_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data;

  bb3_pix_in_if  pix_in_if();
  bb3_pix_out_if pix_out_if();

  box_blur_3x3 #(
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_i       (pix_in_if),
    .out_o      (pix_out_if)
  );

  // blur predictor state
  logic [bb3_pkg::WIDTH_W-1:0]  width_reg;
  logic [bb3_pkg::HEIGHT_W-1:0] height_reg;
  bb3_pkg::pixel_t              upper_row [MAX_WIDTH];
  bb3_pkg::pixel_t              middle_row [MAX_WIDTH];
  bb3_pkg::column_t             win_cols [3];
  int unsigned                  col_pos;
  int unsigned                  row_pos;

  blur_px_t    pending_blur_q[$];
  blur_px_t    head_px;
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  logic        steady_flow;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    return height_reg;
  endfunction

  function automatic void predict_blur(bb3_pkg::pixel_t pix_in, logic drain_in);
    int unsigned wd, ht, c, r, xc, yc, sum;
    bb3_pkg::pixel_t p, top, mid;
    logic hit, is_last;
    bb3_pkg::column_t col;
    wd = eff_width();
    ht = eff_height();
    c = col_pos;
    r = row_pos;
    p = drain_in ? '0 : pix_in;
    hit = 1'b0;
    xc = 0;
    yc = 0;
    sum = 0;
    // position outside the current geometry restarts the frame
    if (c >= wd || r > ht + 1) begin
      c = 0;
      r = 0;
    end
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = p;
    win_cols[0] = win_cols[1];
    win_cols[1] = win_cols[2];
    win_cols[2] = '{top: top, mid: mid, bot: p};
    if (c >= 1) begin
      if (r >= 1) begin
        xc = c - 1;
        yc = r - 1;
        hit = 1'b1;
      end
    end else if (r >= 2) begin
      xc = wd - 1;
      yc = r - 2;
      hit = 1'b1;
    end
    if (hit && yc >= ht) hit = 1'b0;
    if (hit) begin
      for (int s = 0; s < 3; s++) begin
        if (s == 0 && xc < 1) continue;
        if (s == 2 && xc + 1 >= wd) continue;
        col = win_cols[s];
        for (int k = 0; k < 3; k++) begin
          if (k == 0 && yc < 1) continue;
          if (k == 2 && yc + 1 >= ht) continue;
          sum += col[(2 - k) * bb3_pkg::PIX_W +: bb3_pkg::PIX_W];
        end
      end
      is_last = (xc == wd - 1) && (yc == ht - 1);
      pending_blur_q.push_back('{value: bb3_pkg::pixel_t'(sum / 9), frame_end: is_last});
      if (is_last) begin
        col_pos = 0;
        row_pos = 0;
        return;
      end
    end
    c++;
    if (c >= wd) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(bb3_pkg::pixel_t pix, logic drain_in);
    if (!steady_flow && $urandom_range(99) < 11) begin
      pix_in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix_in_if.valid <= 1'b1;
    pix_in_if.pixel_value <= pix;
    pix_in_if.drain <= drain_in;
    do @(posedge clk_i); while (!pix_in_if.ready);
    predict_blur(pix, drain_in);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    pix_in_if.valid <= 1'b0;
    while (pending_blur_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_geometry(int unsigned wd_val, int unsigned ht_val);
    cfg_we <= 1'b1;
    cfg_index <= bb3_pkg::REG_FRAME_WIDTH;
    cfg_data <= wd_val[bb3_pkg::CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_index <= bb3_pkg::REG_FRAME_HEIGHT;
    cfg_data <= ht_val[bb3_pkg::CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
    width_reg = wd_val[bb3_pkg::WIDTH_W-1:0];
    height_reg = ht_val[bb3_pkg::HEIGHT_W-1:0];
  endtask

  // flush until the next item starts a fresh frame
  task automatic realign_frame();
    while (col_pos != 0 || row_pos != 0) send_pixel('0, 1'b1);
  endtask

  task automatic start_geometry(int unsigned wd_val, int unsigned ht_val);
    wait_drained();
    set_geometry(wd_val, ht_val);
    realign_frame();
  endtask

  task automatic send_frame(int unsigned wd, int unsigned ht);
    for (int i = 0; i < wd * ht; i++) begin
      send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), $urandom_range(99) < 3);
    end
    for (int i = 0; i <= wd; i++) begin
      send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), $urandom_range(99) < 90);
    end
  endtask

  task automatic test_reset_geometry();
    repeat (660) send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), 1'b0);
    wait_drained();
  endtask

  // widen the running frame past the columns written so far and wrap at the widest row
  task automatic test_widest_frame();
    int unsigned count;
    set_geometry(2047, 4);
    count = MAX_WIDTH + 3 - col_pos;
    steady_flow = 1'b1;
    repeat (count) send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), 1'b0);
    steady_flow = 1'b0;
    wait_drained();
  endtask

  task automatic test_corner_frames();
    start_geometry(3, 3);
    repeat (4) send_pixel(8'hff, 1'b0);
    send_pixel(8'hff, 1'b1);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'hff, 1'b0);
    // real pixel during the flush is outside the frame
    send_pixel(8'hff, 1'b0);
    repeat (3) send_pixel(8'h00, 1'b1);
    start_geometry(0, 0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'h00, 1'b1);
    send_pixel(8'h00, 1'b1);
  endtask

  task automatic test_resize_mid_frame();
    start_geometry(8, 4095);
    repeat (20) send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), 1'b0);
    wait_drained();
    set_geometry(3, 4095);
    repeat (10) send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), 1'b0);
    wait_drained();
    set_geometry(6, 4095);
    repeat (10) send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), 1'b0);
    wait_drained();
    set_geometry(6, 1);
    repeat (10) send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), 1'b0);
    realign_frame();
    wait_drained();
  endtask

  task automatic test_random_frames();
    int unsigned first_item, wd, ht, kind;
    logic need_geometry;
    first_item = items_sent;
    need_geometry = 1'b1;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (need_geometry || $urandom_range(3) == 0) begin
        start_geometry(($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16),
                       $urandom_range(0, 9));
        need_geometry = 1'b0;
      end
      wd = eff_width();
      ht = eff_height();
      steady_flow = ($urandom_range(9) == 0);
      kind = $urandom_range(99);
      if (kind < 85) begin
        send_frame(wd, ht);
      end else if (kind < 93) begin
        repeat ($urandom_range(1, wd * ht)) begin
          send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), 1'b0);
        end
        need_geometry = 1'b1;
      end else begin
        send_frame(wd, ht);
        repeat ($urandom_range(1, 4)) begin
          send_pixel(bb3_pkg::pixel_t'($urandom_range(255)), $urandom_range(1) == 1);
        end
        need_geometry = 1'b1;
      end
    end
    steady_flow = 1'b0;
  endtask

  always @(negedge clk_i) begin
    pix_out_if.ready <= steady_flow || ($urandom_range(99) >= 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_out_if.valid && pix_out_if.ready) begin
      if (pending_blur_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual value %0d last %0b",
                 $time, pix_out_if.blurred_value, pix_out_if.last_of_frame);
        mismatch_count++;
      end else begin
        head_px = pending_blur_q.pop_front();
        if (pix_out_if.blurred_value !== head_px.value) begin
          $display("%0t: blurred_value expected %0d actual %0d",
                   $time, head_px.value, pix_out_if.blurred_value);
          mismatch_count++;
        end
        if (pix_out_if.last_of_frame !== head_px.frame_end) begin
          $display("%0t: last_of_frame expected %0b actual %0b",
                   $time, head_px.frame_end, pix_out_if.last_of_frame);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix_in_if.valid && pix_in_if.ready) || (pix_out_if.valid && pix_out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bb3_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    pix_in_if.valid = 1'b0;
    pix_in_if.pixel_value = '0;
    pix_in_if.drain = 1'b0;
    pix_out_if.ready = 1'b0;
    steady_flow = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    quiet_cycles = 0;
    width_reg = bb3_pkg::WIDTH_RESET;
    height_reg = bb3_pkg::HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    for (int i = 0; i < 3; i++) win_cols[i] = '0;
    col_pos = 0;
    row_pos = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_geometry();
    test_widest_frame();
    test_corner_frames();
    test_resize_mid_frame();
    test_random_frames();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bb3_pkg.sv
rtl/bb3_stream_if.sv
rtl/bb3_line_mem.sv
rtl/bb3_ctrl.sv
rtl/bb3_window.sv
rtl/box_blur_3x3.sv
rtl/bb3_checker.sv
tb/sv/tb_box_blur_3x3.sv
